FILE: design/lp2p_pkg.sv
`timescale 1ns / 1ps

package lp2p_pkg;

  // Field widths.
  localparam int ANGLE_W = 16;
  localparam int DIST_W  = 18;
  localparam int PIX_W   = 16;
  localparam int SCALE_W = 24;
  localparam int CENTER_W = 12;
  localparam int CFG_IDX_W = 2;

  // CORDIC datapath widths.
  localparam int XY_W   = 18;   // x/y carry a little headroom above Q1.15
  localparam int Z_W    = 33;   // phase, 2^32 units per turn, signed
  localparam int TRIG_W = 15;   // clamped residue sine/cosine magnitude
  localparam int P1_W   = DIST_W + TRIG_W;   // distance * trig
  localparam int P2_W   = P1_W + SCALE_W;    // distance * trig * scale
  localparam int OFF_SHIFT = 33;
  localparam int OFF_W  = P2_W - OFF_SHIFT;  // magnitude of the pixel offset
  localparam int SUM_W  = OFF_W + 2;

  localparam int ANGLE_TABLE_LEN = 24;
  localparam logic [XY_W-1:0] GAIN_Q15 = XY_W'(19899);

  localparam logic [31:0] ATAN_TURN32 [ANGLE_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(6554);
  localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(400);

  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_SCALE = 2'd0,
    CFG_CENTER_X    = 2'd1,
    CFG_CENTER_Y    = 2'd2
  } cfg_idx_t;

  // Quadrant of the beam, clockwise from forward.
  typedef enum logic [1:0] {
    QUAD_FWD   = 2'd0,
    QUAD_RIGHT = 2'd1,
    QUAD_BACK  = 2'd2,
    QUAD_LEFT  = 2'd3
  } quad_t;

  function automatic logic [TRIG_W-1:0] clamp_q15(input logic signed [XY_W-1:0] v);
    logic [TRIG_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(XY_W'(32767))) begin
      r = '1;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/lidar_polar_to_pixel_core.sv
`timescale 1ns / 1ps

// Path: an accepted item passes the load register, the CORDIC stages, the map register, the
// two multiply registers and the output register; the CORDIC stage count sets its length.
// Throughput: one item per cycle; the whole pipeline stalls only while the output
// register holds a result that is not taken.
// Reset: rst clears all valid bits and loads pixel_scale = 6554, center_x = center_y = 400.
module lidar_polar_to_pixel_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [lp2p_pkg::ANGLE_W-1:0] angle_turns,
  input  logic [lp2p_pkg::DIST_W-1:0] distance_qmm,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [lp2p_pkg::PIX_W-1:0] pixel_x,
  output logic signed [lp2p_pkg::PIX_W-1:0] pixel_y,
  output logic clipped,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lp2p_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lp2p_pkg::SCALE_W-1:0] cfg_data
);
  import lp2p_pkg::*;

  localparam int NUM_STAGES = (CORDIC_STAGES < ANGLE_TABLE_LEN) ?
                              CORDIC_STAGES : ANGLE_TABLE_LEN;

  // Configuration registers.
  logic [SCALE_W-1:0]  pixel_scale;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_scale <= SCALE_RESET;
      center_x    <= CENTER_RESET;
      center_y    <= CENTER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PIXEL_SCALE: pixel_scale <= cfg_data;
        CFG_CENTER_X:    center_x    <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y:    center_y    <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless the output register is full and stalled.
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // CORDIC stages: index 0 holds the loaded item, index k the item after k iterations.
  logic [NUM_STAGES:0]     v_pipe;
  logic signed [XY_W-1:0]  x_pipe [0:NUM_STAGES];
  logic signed [XY_W-1:0]  y_pipe [0:NUM_STAGES];
  logic signed [Z_W-1:0]   z_pipe [0:NUM_STAGES];
  quad_t                   quad_pipe [0:NUM_STAGES];
  logic [DIST_W-1:0]       d_pipe [0:NUM_STAGES];

  always_ff @(posedge clk) begin
    if (advance) begin
      x_pipe[0]    <= $signed(GAIN_Q15);
      y_pipe[0]    <= '0;
      z_pipe[0]    <= $signed({3'b000, angle_turns[ANGLE_W-3:0], 16'h0000});
      quad_pipe[0] <= quad_t'(angle_turns[ANGLE_W-1:ANGLE_W-2]);
      d_pipe[0]    <= distance_qmm;
    end
  end

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cordic
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  step;
    logic                   rot_pos;

    assign dx      = x_pipe[i] >>> i;
    assign dy      = y_pipe[i] >>> i;
    assign step    = $signed({1'b0, ATAN_TURN32[i]});
    assign rot_pos = !z_pipe[i][Z_W-1];

    always_ff @(posedge clk) begin
      if (advance) begin
        if (rot_pos) begin
          x_pipe[i+1] <= x_pipe[i] - dy;
          y_pipe[i+1] <= y_pipe[i] + dx;
          z_pipe[i+1] <= z_pipe[i] - step;
        end else begin
          x_pipe[i+1] <= x_pipe[i] + dy;
          y_pipe[i+1] <= y_pipe[i] - dx;
          z_pipe[i+1] <= z_pipe[i] + step;
        end
        quad_pipe[i+1] <= quad_pipe[i];
        d_pipe[i+1]    <= d_pipe[i];
      end
    end
  end

  // Quadrant mapping: magnitude and sign of s for x, and of -c for y.
  logic [TRIG_W-1:0] sr, cr;
  logic [TRIG_W-1:0] mag_x_next, mag_y_next;
  logic              neg_x_next, neg_y_next;

  assign sr = clamp_q15(y_pipe[NUM_STAGES]);
  assign cr = clamp_q15(x_pipe[NUM_STAGES]);

  always_comb begin
    unique case (quad_pipe[NUM_STAGES])
      QUAD_FWD: begin
        mag_x_next = sr; neg_x_next = 1'b0;
        mag_y_next = cr; neg_y_next = 1'b1;
      end
      QUAD_RIGHT: begin
        mag_x_next = cr; neg_x_next = 1'b0;
        mag_y_next = sr; neg_y_next = 1'b0;
      end
      QUAD_BACK: begin
        mag_x_next = sr; neg_x_next = 1'b1;
        mag_y_next = cr; neg_y_next = 1'b0;
      end
      default: begin
        mag_x_next = cr; neg_x_next = 1'b1;
        mag_y_next = sr; neg_y_next = 1'b1;
      end
    endcase
  end

  logic                v_map;
  logic [TRIG_W-1:0]   mag_x, mag_y;
  logic                neg_x_map, neg_y_map;
  logic [DIST_W-1:0]   d_map;

  logic                v_mul1;
  logic [P1_W-1:0]     p1_x, p1_y;
  logic                neg_x_mul1, neg_y_mul1;

  logic                v_mul2;
  logic [P2_W-1:0]     p2_x, p2_y;
  logic                neg_x_mul2, neg_y_mul2;

  always_ff @(posedge clk) begin
    if (advance) begin
      mag_x     <= mag_x_next;
      mag_y     <= mag_y_next;
      neg_x_map <= neg_x_next;
      neg_y_map <= neg_y_next;
      d_map     <= d_pipe[NUM_STAGES];

      p1_x       <= P1_W'(d_map) * P1_W'(mag_x);
      p1_y       <= P1_W'(d_map) * P1_W'(mag_y);
      neg_x_mul1 <= neg_x_map;
      neg_y_mul1 <= neg_y_map;

      p2_x       <= P2_W'(p1_x) * P2_W'(pixel_scale);
      p2_y       <= P2_W'(p1_y) * P2_W'(pixel_scale);
      neg_x_mul2 <= neg_x_mul1;
      neg_y_mul2 <= neg_y_mul1;
    end
  end

  // Offset is truncated toward zero: the sign goes on after the shift of the magnitude.
  logic signed [SUM_W-1:0] off_x, off_y, sum_x, sum_y;
  logic signed [PIX_W-1:0] pixel_x_next, pixel_y_next;
  logic                    clip_x, clip_y;

  always_comb begin
    off_x = $signed({2'b00, p2_x[P2_W-1:OFF_SHIFT]});
    off_y = $signed({2'b00, p2_y[P2_W-1:OFF_SHIFT]});
    if (neg_x_mul2) begin
      off_x = -off_x;
    end
    if (neg_y_mul2) begin
      off_y = -off_y;
    end
    sum_x = $signed({{(SUM_W-CENTER_W){1'b0}}, center_x}) + off_x;
    sum_y = $signed({{(SUM_W-CENTER_W){1'b0}}, center_y}) + off_y;

    clip_x = 1'b1;
    if (sum_x > SUM_W'(PIX_MAX)) begin
      pixel_x_next = PIX_MAX;
    end else if (sum_x < SUM_W'(PIX_MIN)) begin
      pixel_x_next = PIX_MIN;
    end else begin
      pixel_x_next = sum_x[PIX_W-1:0];
      clip_x       = 1'b0;
    end

    clip_y = 1'b1;
    if (sum_y > SUM_W'(PIX_MAX)) begin
      pixel_y_next = PIX_MAX;
    end else if (sum_y < SUM_W'(PIX_MIN)) begin
      pixel_y_next = PIX_MIN;
    end else begin
      pixel_y_next = sum_y[PIX_W-1:0];
      clip_y       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_x <= pixel_x_next;
      pixel_y <= pixel_y_next;
      clipped <= clip_x || clip_y;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe    <= '0;
      v_map     <= 1'b0;
      v_mul1    <= 1'b0;
      v_mul2    <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v_pipe    <= {v_pipe[NUM_STAGES-1:0], in_valid};
      v_map     <= v_pipe[NUM_STAGES];
      v_mul1    <= v_map;
      v_mul2    <= v_mul1;
      out_valid <= v_mul2;
    end
  end

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !out_valid && !v_mul2 && !v_map && (v_pipe == '0))
    else $error("pipeline not empty after reset");

  // A stalled pipeline neither drops nor duplicates items.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable({v_pipe, v_map, v_mul1, v_mul2}))
    else $error("pipeline valid bits moved during stall");

  // Clipping is only reported when a coordinate sits at a rail.
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (pixel_x == PIX_MAX) || (pixel_x == PIX_MIN) ||
      (pixel_y == PIX_MAX) || (pixel_y == PIX_MIN))
    else $error("clipped set with both coordinates inside range");

endmodule
